/* rtl/rotated_framebuffer_pixel_writer_top_macros.svh */
// assertion macros used by the checker file
`ifndef ROTATED_FRAMEBUFFER_PIXEL_WRITER_TOP_MACROS_SVH
`define ROTATED_FRAMEBUFFER_PIXEL_WRITER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RFPW_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfpw check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RFPW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfpw check failed");

`endif

/* rtl/rfpw_pkg.sv */
// shared constants, codes and interface structs of the framebuffer pixel writer
package rfpw_pkg;

    localparam int FB_BYTES = 16384;
    localparam int FB_AW    = $clog2(FB_BYTES);
    localparam int MAX_DIM  = 1024;
    localparam int DIM_W    = 11;
    localparam int COORD_W  = 10;
    localparam int PITCH_W  = $clog2(MAX_DIM / 4 + 1);
    localparam int PROD_W   = COORD_W + PITCH_W;
    localparam int TOTAL_W  = DIM_W + PITCH_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_MEM_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_BIT_MODE = 3'd4;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd128;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd296;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [1:0] STATUS_WRITTEN  = 2'd0;
    localparam logic [1:0] STATUS_REJECTED = 2'd1;
    localparam logic [1:0] STATUS_CLEARED  = 2'd2;

    localparam logic [7:0] BIT_MSB   = 8'h80;
    localparam logic [7:0] FIELD_MSB = 8'hC0;
    localparam logic [7:0] FIELD_REP = 8'h55;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [1:0]       rotation;
        logic [1:0]       mirror;
        logic             two_bit;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic map;
        logic addr;
        logic read;
        logic pix_write;
        logic fill_step;
        logic init;
        logic emit_reject;
        logic emit_clear;
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic pix_ok;
        logic total_zero;
        logic fill_last;
    } stat_t;

endpackage

/* rtl/rfpw_cfg.sv */
// configuration registers with panel size clamping
module rfpw_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rfpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfpw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output rfpw_pkg::cfg_t                      cfg
);

    logic [rfpw_pkg::DIM_W-1:0] width_reg;
    logic [rfpw_pkg::DIM_W-1:0] height_reg;
    logic [1:0]                 rotation_reg;
    logic [1:0]                 mirror_reg;
    logic                       two_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= rfpw_pkg::RESET_WIDTH;
            height_reg   <= rfpw_pkg::RESET_HEIGHT;
            rotation_reg <= rfpw_pkg::ROT_0;
            mirror_reg   <= 2'd0;
            two_bit_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rfpw_pkg::REG_MEM_WIDTH:    width_reg    <= cfg_wdata;
                rfpw_pkg::REG_MEM_HEIGHT:   height_reg   <= cfg_wdata;
                rfpw_pkg::REG_ROTATION:     rotation_reg <= cfg_wdata[1:0];
                rfpw_pkg::REG_MIRROR_MODE:  mirror_reg   <= cfg_wdata[1:0];
                rfpw_pkg::REG_TWO_BIT_MODE: two_bit_reg  <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // oversized panels behave as the largest supported one
    always_comb
    begin
        cfg.width    = (width_reg > rfpw_pkg::DIM_W'(rfpw_pkg::MAX_DIM))
                       ? rfpw_pkg::DIM_W'(rfpw_pkg::MAX_DIM) : width_reg;
        cfg.height   = (height_reg > rfpw_pkg::DIM_W'(rfpw_pkg::MAX_DIM))
                       ? rfpw_pkg::DIM_W'(rfpw_pkg::MAX_DIM) : height_reg;
        cfg.rotation = rotation_reg;
        cfg.mirror   = mirror_reg;
        cfg.two_bit  = two_bit_reg;
    end

endmodule

/* rtl/rfpw_ctrl.sv */
// sequencing state machine of the pixel writer
module rfpw_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  rfpw_pkg::stat_t stat,
    output rfpw_pkg::cmd_t  cmd,
    output logic            busy
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MAP,
        ST_ADDR,
        ST_CHECK,
        ST_MODIFY,
        ST_FILL
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:   if (stat.fill_last) state_next = ST_IDLE;
            ST_IDLE:   if (start) state_next = ST_MAP;
            ST_MAP:    state_next = ST_ADDR;
            ST_ADDR:   state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (stat.is_clear)
                    state_next = stat.total_zero ? ST_IDLE : ST_FILL;
                else
                    state_next = stat.pix_ok ? ST_MODIFY : ST_IDLE;
            end
            ST_MODIFY: state_next = ST_IDLE;
            ST_FILL:   if (stat.fill_last) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    always_comb
    begin
        cmd.load        = (state_reg == ST_IDLE) && start;
        cmd.map         = (state_reg == ST_MAP);
        cmd.addr        = (state_reg == ST_ADDR);
        cmd.read        = (state_reg == ST_CHECK) && !stat.is_clear && stat.pix_ok;
        cmd.emit_reject = (state_reg == ST_CHECK) && !stat.is_clear && !stat.pix_ok;
        cmd.emit_clear  = ((state_reg == ST_CHECK) && stat.is_clear && stat.total_zero)
                          || ((state_reg == ST_FILL) && stat.fill_last);
        cmd.pix_write   = (state_reg == ST_MODIFY);
        cmd.fill_step   = (state_reg == ST_FILL) || (state_reg == ST_INIT);
        cmd.init        = (state_reg == ST_INIT);
    end

    assign busy = busy_reg;

endmodule

/* rtl/rfpw_dp.sv */
// coordinate mapping, address arithmetic, framebuffer memory and result registers
module rfpw_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rfpw_pkg::cmd_t                    cmd,
    input  rfpw_pkg::cfg_t                    cfg,
    input  logic                              command,
    input  logic [rfpw_pkg::COORD_W-1:0]      x_coord,
    input  logic [rfpw_pkg::COORD_W-1:0]      y_coord,
    input  logic [7:0]                        color,
    output rfpw_pkg::stat_t                   stat,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [rfpw_pkg::FB_AW-1:0]        byte_addr,
    output logic [7:0]                        byte_value
);

    localparam int DW = rfpw_pkg::DIM_W;
    localparam int CW = rfpw_pkg::COORD_W;
    localparam int AW = rfpw_pkg::FB_AW;
    localparam int PW = rfpw_pkg::PITCH_W;

    // latched transaction
    logic          clear_reg;
    logic [CW-1:0] x_reg, y_reg;
    logic [7:0]    color_reg;
    // mapped coordinates
    logic [CW-1:0] xf_reg, yf_reg;
    logic          in_ok_reg;
    logic [PW-1:0] pitch_reg;
    // address stage
    logic [AW-1:0] addr_reg;
    logic          addr_ok_reg;
    logic [AW-1:0] last_reg;
    logic          total_zero_reg;
    logic [7:0]    fill_reg;
    // memory
    logic [7:0]    frame_store_reg [rfpw_pkg::FB_BYTES];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] fill_idx_reg;
    // results
    logic          done_reg;
    logic [1:0]    status_reg;
    logic [AW-1:0] byte_addr_reg;
    logic [7:0]    byte_value_reg;

    // mapping
    logic [DW-1:0] xe, ye, lw, lh, wm1, hm1, xm, ym, xr, yr;
    logic          in_ok;
    logic [DW:0]   w_up1, w_up2;
    logic [PW-1:0] pitch;

    always_comb
    begin
        xe  = DW'(x_reg);
        ye  = DW'(y_reg);
        lw  = cfg.rotation[0] ? cfg.height : cfg.width;
        lh  = cfg.rotation[0] ? cfg.width : cfg.height;
        in_ok = (xe < lw) && (ye < lh);
        wm1 = cfg.width - DW'(1);
        hm1 = cfg.height - DW'(1);
        case (cfg.rotation)
            rfpw_pkg::ROT_0:
            begin
                xm = xe;
                ym = ye;
            end
            rfpw_pkg::ROT_90:
            begin
                xm = wm1 - ye;
                ym = xe;
            end
            rfpw_pkg::ROT_180:
            begin
                xm = wm1 - xe;
                ym = hm1 - ye;
            end
            default:
            begin
                xm = ye;
                ym = hm1 - xe;
            end
        endcase
        xr = cfg.mirror[0] ? (wm1 - xm) : xm;
        yr = cfg.mirror[1] ? (hm1 - ym) : ym;
        // bytes per row, rounded up
        w_up1 = {1'b0, cfg.width} + (DW + 1)'(3);
        w_up2 = {1'b0, cfg.width} + (DW + 1)'(7);
        pitch = cfg.two_bit ? PW'(w_up1 >> 2) : PW'(w_up2 >> 3);
    end

    // address and clear size
    logic [rfpw_pkg::PROD_W-1:0]  prod, col;
    logic [rfpw_pkg::PROD_W:0]    sum;
    logic [rfpw_pkg::TOTAL_W-1:0] total;
    logic [AW-1:0]                last;
    logic [7:0]                   fill_val;

    always_comb
    begin
        prod = rfpw_pkg::PROD_W'(yf_reg) * rfpw_pkg::PROD_W'(pitch_reg);
        col  = cfg.two_bit ? rfpw_pkg::PROD_W'(xf_reg >> 2)
                           : rfpw_pkg::PROD_W'(xf_reg >> 3);
        sum  = {1'b0, prod} + {1'b0, col};
        total = rfpw_pkg::TOTAL_W'(pitch_reg) * rfpw_pkg::TOTAL_W'(cfg.height);
        last  = (total >= rfpw_pkg::TOTAL_W'(rfpw_pkg::FB_BYTES))
                ? AW'(rfpw_pkg::FB_BYTES - 1) : AW'(total - rfpw_pkg::TOTAL_W'(1));
        // 2 bpp replicates the field into all four slots
        fill_val = cfg.two_bit ? (rfpw_pkg::FIELD_REP * {6'd0, color_reg[1:0]})
                               : color_reg;
    end

    // read-modify-write
    logic [7:0] bit_mask, fld_mask, fld_val, new_val;
    logic [2:0] sh;

    always_comb
    begin
        bit_mask = rfpw_pkg::BIT_MSB >> xf_reg[2:0];
        sh       = {xf_reg[1:0], 1'b0};
        fld_mask = rfpw_pkg::FIELD_MSB >> sh;
        fld_val  = {color_reg[1:0], 6'd0} >> sh;
        if (cfg.two_bit)
            new_val = (rdata_reg & ~fld_mask) | fld_val;
        else if (color_reg == 8'd0)
            new_val = rdata_reg & ~bit_mask;
        else
            new_val = rdata_reg | bit_mask;
    end

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          fill_last;

    always_comb
    begin
        fill_last = (fill_idx_reg == (cmd.init ? AW'(rfpw_pkg::FB_BYTES - 1) : last_reg));
        wr_en     = cmd.pix_write || cmd.fill_step;
        wr_addr   = cmd.pix_write ? addr_reg : fill_idx_reg;
        if (cmd.pix_write)
            wr_data = new_val;
        else
            wr_data = cmd.init ? 8'd0 : fill_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_store_reg[wr_addr] <= wr_data;
        if (cmd.read)
            rdata_reg <= frame_store_reg[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            clear_reg <= command;
            x_reg     <= x_coord;
            y_reg     <= y_coord;
            color_reg <= color;
        end
        if (cmd.map)
        begin
            xf_reg    <= CW'(xr);
            yf_reg    <= CW'(yr);
            in_ok_reg <= in_ok;
            pitch_reg <= pitch;
        end
        if (cmd.addr)
        begin
            addr_reg       <= AW'(sum);
            addr_ok_reg    <= in_ok_reg
                              && (sum < (rfpw_pkg::PROD_W + 1)'(rfpw_pkg::FB_BYTES));
            last_reg       <= last;
            total_zero_reg <= (total == '0);
            fill_reg       <= fill_val;
        end
        if (cmd.pix_write)
        begin
            status_reg     <= rfpw_pkg::STATUS_WRITTEN;
            byte_addr_reg  <= addr_reg;
            byte_value_reg <= new_val;
        end
        else if (cmd.emit_reject)
        begin
            status_reg     <= rfpw_pkg::STATUS_REJECTED;
            byte_addr_reg  <= '0;
            byte_value_reg <= 8'd0;
        end
        else if (cmd.emit_clear)
        begin
            status_reg     <= rfpw_pkg::STATUS_CLEARED;
            byte_addr_reg  <= total_zero_reg ? '0 : last_reg;
            byte_value_reg <= fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.fill_step)
                fill_idx_reg <= fill_last ? '0 : fill_idx_reg + AW'(1);
            done_reg <= cmd.pix_write || cmd.emit_reject || cmd.emit_clear;
        end
    end

    always_comb
    begin
        stat.is_clear   = clear_reg;
        stat.pix_ok     = addr_ok_reg;
        stat.total_zero = total_zero_reg;
        stat.fill_last  = fill_last;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign byte_addr  = byte_addr_reg;
    assign byte_value = byte_value_reg;

endmodule

/* rtl/rotated_framebuffer_pixel_writer_top.sv */
// top level of the rotated framebuffer pixel writer
// usage:
//   a transaction is taken when start is high and busy is low; command 0 writes
//   one pixel at logical (x_coord, y_coord), command 1 fills the used part of the buffer
//   every transaction gives exactly one result: done is high for one cycle with
//   status, byte_addr and byte_value; the receiver cannot hold results off
//   a pixel write runs latch, coordinate map, address multiply, memory read, and
//   modify and write before the next transaction can be taken, and done is
//   registered from the modify and write step
//   a clear fills pitch * height bytes, capped at 16384, through the
//   single memory write port, one byte per cycle
//   out-of-range pixels come back as rejected from the check step, without a
//   memory access, and the block then takes the next transaction
//   after reset busy stays high while the whole framebuffer is zeroed one byte
//   per cycle; configuration writes are taken at any time
//   configuration is written through cfg_we, cfg_index and cfg_wdata and must
//   only change while no transaction is in flight
module rotated_framebuffer_pixel_writer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [rfpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfpw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                command,
    input  logic [rfpw_pkg::COORD_W-1:0]        x_coord,
    input  logic [rfpw_pkg::COORD_W-1:0]        y_coord,
    input  logic [7:0]                          color,
    // result channel
    output logic                                done,
    output logic [1:0]                          status,
    output logic [rfpw_pkg::FB_AW-1:0]          byte_addr,
    output logic [7:0]                          byte_value
);

    rfpw_pkg::cfg_t  cfg;
    rfpw_pkg::cmd_t  cmd;
    rfpw_pkg::stat_t stat;

    // register file, clamps oversized panel dimensions
    rfpw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sequencer: reset clearing pass, pixel steps and clear walk
    rfpw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // mapping, addressing, framebuffer and result registers
    rfpw_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .command    (command),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .color      (color),
        .stat       (stat),
        .done       (done),
        .status     (status),
        .byte_addr  (byte_addr),
        .byte_value (byte_value)
    );

endmodule

/* rtl/rfpw_checker.sv */
// port-level checks of the pixel writer and their binding
`include "rotated_framebuffer_pixel_writer_top_macros.svh"

module rfpw_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [1:0]                     status,
    input logic [rfpw_pkg::FB_AW-1:0]     byte_addr,
    input logic [7:0]                     byte_value
);

    // a result only appears once the block has gone idle
    `RFPW_ASSERT_IMPLY(a_done_idle, done, !busy)
    // an accepted transaction always makes the block busy
    `RFPW_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // a strobe is never stretched into a second result
    `RFPW_ASSERT_NEXT(a_done_single, done, !done)
    // rejected pixels report an empty byte
    `RFPW_ASSERT_IMPLY(a_reject_zero, done && (status == rfpw_pkg::STATUS_REJECTED),
        (byte_addr == '0) && (byte_value == 8'd0))

endmodule

bind rotated_framebuffer_pixel_writer_top rfpw_checker u_rfpw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .byte_addr  (byte_addr),
    .byte_value (byte_value)
);

/* tb/sv/rotated_framebuffer_pixel_writer_top_test.sv */
// self-checking testbench for the rotated framebuffer pixel writer top level
`timescale 1ns / 100ps

module rotated_framebuffer_pixel_writer_top_test;
    import rfpw_pkg::*;

    // command codes and mirror settings as the block interprets them
    localparam logic       CMD_PIXEL     = 1'b0;
    localparam logic       CMD_CLEAR     = 1'b1;
    localparam logic [1:0] MIRROR_OFF    = 2'd0;
    localparam logic [1:0] MIRROR_HORIZ  = 2'd1;
    localparam logic [1:0] MIRROR_VERT   = 2'd2;
    localparam logic [1:0] MIRROR_BOTH   = 2'd3;

    // kinds of row in the directed table, and whether a row carries its own answer
    localparam logic ROW_CMD = 1'b0;
    localparam logic ROW_CFG = 1'b1;
    localparam logic NOCHK   = 1'b0;
    localparam logic CHK     = 1'b1;

    localparam int N_PHASES        = 12;
    localparam int OPS_PER_PHASE   = 136;
    localparam int SETTLE_CYCLES   = 10;
    // a full-buffer clear or the zeroing pass after reset walks all 16384 bytes with no handshake
    localparam int STALL_LIMIT     = 70000;
    localparam int MAX_PRINTS      = 40;
    // sender idling per phase: none, heavy, none, moderate
    localparam int IDLE_PCT [4]    = '{0, 49, 0, 35};

    typedef struct packed {
        logic [1:0]       status;
        logic [FB_AW-1:0] addr;
        logic [7:0]       value;
    } frame_result_t;

    typedef struct packed {
        logic                  kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  op;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [7:0]            ink;
        logic                  chk;
        logic [1:0]            st;
        logic [FB_AW-1:0]      addr;
        logic [7:0]            val;
    } stim_row_t;

    localparam int N_ROWS = 40;

    // directed table, walked in order; rows marked CHK carry the answer typed in,
    // the rest are scored against the shadow framebuffer
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        // reset panel 128 x 296, 1 bpp, pitch 16
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd0, 10'd0, 8'hFF, CHK, STATUS_WRITTEN, 14'd0, 8'h80},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd127, 10'd295, 8'h01, CHK, STATUS_WRITTEN,
          14'd4735, 8'h01},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd1023, 10'd1023, 8'h00, CHK, STATUS_REJECTED,
          14'd0, 8'h00},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd128, 10'd0, 8'h01, CHK, STATUS_REJECTED, 14'd0, 8'h00},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd0, 10'd296, 8'h01, CHK, STATUS_REJECTED, 14'd0, 8'h00},
        '{ROW_CMD, '0, '0, CMD_CLEAR, 10'd0, 10'd0, 8'hA5, CHK, STATUS_CLEARED, 14'd4735, 8'hA5},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd0, 10'd0, 8'h00, CHK, STATUS_WRITTEN, 14'd0, 8'h25},
        // 2 bpp, pitch 32
        '{ROW_CFG, REG_TWO_BIT_MODE, 11'd1, CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd1, 10'd0, 8'hFE, NOCHK, '0, '0, '0},
        '{ROW_CMD, '0, '0, CMD_CLEAR, 10'd0, 10'd0, 8'h03, CHK, STATUS_CLEARED, 14'd9471, 8'hFF},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd3, 10'd1, 8'h00, NOCHK, '0, '0, '0},
        // quarter turn swaps the logical size to 296 x 128
        '{ROW_CFG, REG_ROTATION, 11'(ROT_90), CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd295, 10'd127, 8'h02, NOCHK, '0, '0, '0},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd296, 10'd0, 8'h01, CHK, STATUS_REJECTED, 14'd0, 8'h00},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd0, 10'd128, 8'h01, CHK, STATUS_REJECTED, 14'd0, 8'h00},
        '{ROW_CFG, REG_ROTATION, 11'(ROT_180), CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CFG, REG_MIRROR_MODE, 11'(MIRROR_HORIZ), CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd5, 10'd7, 8'h01, NOCHK, '0, '0, '0},
        '{ROW_CFG, REG_ROTATION, 11'(ROT_270), CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CFG, REG_MIRROR_MODE, 11'(MIRROR_BOTH), CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd0, 10'd0, 8'h03, NOCHK, '0, '0, '0},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd200, 10'd100, 8'h01, NOCHK, '0, '0, '0},
        '{ROW_CFG, REG_ROTATION, 11'(ROT_0), CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CFG, REG_MIRROR_MODE, 11'(MIRROR_VERT), CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd9, 10'd9, 8'hFF, NOCHK, '0, '0, '0},
        // oversized panel, clamped to 1024 x 1024 at pitch 128
        '{ROW_CFG, REG_MIRROR_MODE, 11'(MIRROR_OFF), CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CFG, REG_TWO_BIT_MODE, 11'd0, CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CFG, REG_MEM_WIDTH, 11'd2047, CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CFG, REG_MEM_HEIGHT, 11'd2047, CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd1023, 10'd1023, 8'h01, CHK, STATUS_REJECTED,
          14'd0, 8'h00},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd1023, 10'd127, 8'h01, CHK, STATUS_WRITTEN,
          14'd16383, 8'h01},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd0, 10'd128, 8'h01, CHK, STATUS_REJECTED, 14'd0, 8'h00},
        '{ROW_CMD, '0, '0, CMD_CLEAR, 10'd0, 10'd0, 8'h00, CHK, STATUS_CLEARED, 14'd16383, 8'h00},
        // zero-sized panels: nothing is drawn, a clear fills nothing
        '{ROW_CFG, REG_MEM_WIDTH, 11'd0, CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd0, 10'd0, 8'h01, CHK, STATUS_REJECTED, 14'd0, 8'h00},
        '{ROW_CMD, '0, '0, CMD_CLEAR, 10'd0, 10'd0, 8'h5A, CHK, STATUS_CLEARED, 14'd0, 8'h5A},
        '{ROW_CFG, REG_MEM_WIDTH, 11'd1, CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CFG, REG_MEM_HEIGHT, 11'd0, CMD_PIXEL, '0, '0, '0, NOCHK, '0, '0, '0},
        '{ROW_CMD, '0, '0, CMD_CLEAR, 10'd0, 10'd0, 8'h01, CHK, STATUS_CLEARED, 14'd0, 8'h01},
        '{ROW_CMD, '0, '0, CMD_PIXEL, 10'd0, 10'd0, 8'hFF, CHK, STATUS_REJECTED, 14'd0, 8'h00}
    };

    // every input has a known value from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  start     = 1'b0;
    logic                  command   = 1'b0;
    logic [COORD_W-1:0]    x_coord   = '0;
    logic [COORD_W-1:0]    y_coord   = '0;
    logic [7:0]            color     = '0;
    logic                  busy;
    logic                  done;
    logic [1:0]            status;
    logic [FB_AW-1:0]      byte_addr;
    logic [7:0]            byte_value;

    // typed-in answer travelling alongside the transaction it belongs to
    logic          typed_row    = 1'b0;
    frame_result_t typed_result = '0;

    // shadow of the framebuffer and of the panel registers
    logic [7:0]    shadow_fb [FB_BYTES];
    cfg_t          panel_cfg;
    frame_result_t results_due [$];
    logic          nothing_due = 1'b1;

    int idle_pct     = 0;
    int fail_count   = 0;
    int ops_taken    = 0;
    int n_written    = 0;
    int n_rejected   = 0;
    int n_cleared    = 0;
    int stall_cycles = 0;

    rotated_framebuffer_pixel_writer_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .color      (color),
        .done       (done),
        .status     (status),
        .byte_addr  (byte_addr),
        .byte_value (byte_value)
    );

    always #5 clk = ~clk;

    // one line per mismatch, printing capped so a broken block cannot flood the log
    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // works out what one pixel or clear transaction does to the shadow framebuffer
    function automatic frame_result_t model_frame_op(input logic op,
                                                     input logic [COORD_W-1:0] px,
                                                     input logic [COORD_W-1:0] py,
                                                     input logic [7:0] ink);
        int unsigned   w, h, pitch, lw, lh, xf, yf, addr, total, sh;
        logic [7:0]    fill, cur;
        frame_result_t r;
        w     = (panel_cfg.width > MAX_DIM) ? MAX_DIM : panel_cfg.width;
        h     = (panel_cfg.height > MAX_DIM) ? MAX_DIM : panel_cfg.height;
        pitch = panel_cfg.two_bit ? (w + 3) / 4 : (w + 7) / 8;
        if (op == CMD_CLEAR)
        begin
            fill  = panel_cfg.two_bit ? {4{ink[1:0]}} : ink;
            total = pitch * h;
            if (total > FB_BYTES)
                total = FB_BYTES;
            for (int unsigned i = 0; i < total; i++)
                shadow_fb[i] = fill;
            r.status = STATUS_CLEARED;
            r.addr   = (total == 0) ? '0 : FB_AW'(total - 1);
            r.value  = fill;
            return r;
        end
        r  = '{STATUS_REJECTED, '0, '0};
        lw = panel_cfg.rotation[0] ? h : w;
        lh = panel_cfg.rotation[0] ? w : h;
        if (px >= lw || py >= lh)
            return r;
        case (panel_cfg.rotation)
            ROT_0:
            begin
                xf = px;
                yf = py;
            end
            ROT_90:
            begin
                xf = w - 1 - py;
                yf = px;
            end
            ROT_180:
            begin
                xf = w - 1 - px;
                yf = h - 1 - py;
            end
            default:
            begin
                xf = py;
                yf = h - 1 - px;
            end
        endcase
        if (panel_cfg.mirror[0])
            xf = w - 1 - xf;
        if (panel_cfg.mirror[1])
            yf = h - 1 - yf;
        if (panel_cfg.two_bit)
        begin
            addr = xf / 4 + yf * pitch;
            sh   = (xf % 4) * 2;
        end
        else
        begin
            addr = xf / 8 + yf * pitch;
            sh   = xf % 8;
        end
        if (addr >= FB_BYTES)
            return r;
        cur = shadow_fb[addr];
        if (panel_cfg.two_bit)
            cur = (cur & ~(FIELD_MSB >> sh)) | ({ink[1:0], 6'b0} >> sh);
        else if (ink == 8'h00)
            cur = cur & ~(BIT_MSB >> sh);
        else
            cur = cur | (BIT_MSB >> sh);
        shadow_fb[addr] = cur;
        r = '{STATUS_WRITTEN, FB_AW'(addr), cur};
        return r;
    endfunction

    // panel sizes lean small so clears stay short, with the odd huge or zero one
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return '0;
        if (roll < 70)
            return CFG_DATA_W'($urandom_range(64, 1));
        if (roll < 93)
            return CFG_DATA_W'($urandom_range(1024, 65));
        return CFG_DATA_W'($urandom_range(2047, 1025));
    endfunction

    // presents one transaction, dropping start at random while it waits to be taken
    task automatic send_frame_op(input logic op, input logic [COORD_W-1:0] px,
                                 input logic [COORD_W-1:0] py, input logic [7:0] ink,
                                 input logic chk, input frame_result_t answer);
        bit taken;
        taken = 1'b0;
        while (!taken)
        begin
            if ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
            end
            else
            begin
                start        <= 1'b1;
                command      <= op;
                x_coord      <= px;
                y_coord      <= py;
                color        <= ink;
                typed_row    <= chk;
                typed_result <= answer;
            end
            @(posedge clk);
            taken = start && !busy;
        end
    endtask

    // block quiet: nothing outstanding, busy low, then a short settle
    task automatic wait_for_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (!nothing_due || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; the caller drops the write enable after a burst
    task automatic write_panel_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_MEM_WIDTH:    panel_cfg.width    = val;
            REG_MEM_HEIGHT:   panel_cfg.height   = val;
            REG_ROTATION:     panel_cfg.rotation = val[1:0];
            REG_MIRROR_MODE:  panel_cfg.mirror   = val[1:0];
            REG_TWO_BIT_MODE: panel_cfg.two_bit  = val[0];
            default: ;
        endcase
    endtask

    // scoreboard: pops the oldest expectation per done strobe, queues a new one per
    // accepted transaction, and keeps the watchdog on cycles with no handshake
    always @(posedge clk)
    begin : result_monitor
        frame_result_t want;
        bit            moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                moved = 1'b1;
                if (results_due.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing outstanding: %0d %0d 0x%02h",
                                              status, byte_addr, byte_value));
                end
                else
                begin
                    want = results_due.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (byte_addr !== want.addr)
                        report_mismatch($sformatf("byte_addr %0d, expected %0d",
                                                  byte_addr, want.addr));
                    if (byte_value !== want.value)
                        report_mismatch($sformatf("byte_value 0x%02h, expected 0x%02h",
                                                  byte_value, want.value));
                    case (want.status)
                        STATUS_WRITTEN:  n_written++;
                        STATUS_REJECTED: n_rejected++;
                        default:         n_cleared++;
                    endcase
                end
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                // the shadow store always moves on, even where the answer is typed in
                want = model_frame_op(command, x_coord, y_coord, color);
                if (typed_row)
                    want = typed_result;
                results_due.push_back(want);
                ops_taken++;
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                     STALL_LIMIT, results_due.size());
            $display("rotated_framebuffer_pixel_writer_top_test NOT OK");
            $finish;
        end
        nothing_due <= (results_due.size() == 0);
    end

    initial
    begin : stimulus
        stim_row_t             row;
        logic                  op;
        logic [COORD_W-1:0]    px, py;
        logic [7:0]            ink;
        int unsigned           w_eff, h_eff, lw, lh;

        foreach (shadow_fb[i])
            shadow_fb[i] = 8'h00;
        panel_cfg = '{RESET_WIDTH, RESET_HEIGHT, ROT_0, MIRROR_OFF, 1'b0};

        // reset held low from time zero and released on an edge; the block then
        // zeroes its store with busy high, which the first send just waits out
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        for (int i = 0; i < N_ROWS; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_CFG)
            begin
                wait_for_idle();
                write_panel_reg(row.reg_idx, row.reg_val);
                cfg_we <= 1'b0;
            end
            else
            begin
                send_frame_op(row.op, row.x, row.y, row.ink, row.chk,
                              '{row.st, row.addr, row.val});
            end
        end

        // random phases: a fresh panel setting each time, all registers rewritten
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            wait_for_idle();
            idle_pct = IDLE_PCT[phase % 4];
            write_panel_reg(REG_MEM_WIDTH, pick_dim());
            write_panel_reg(REG_MEM_HEIGHT, pick_dim());
            write_panel_reg(REG_ROTATION, CFG_DATA_W'($urandom_range(3)));
            write_panel_reg(REG_MIRROR_MODE, CFG_DATA_W'($urandom_range(3)));
            write_panel_reg(REG_TWO_BIT_MODE, CFG_DATA_W'($urandom_range(1)));
            cfg_we <= 1'b0;

            w_eff = (panel_cfg.width > MAX_DIM) ? MAX_DIM : panel_cfg.width;
            h_eff = (panel_cfg.height > MAX_DIM) ? MAX_DIM : panel_cfg.height;
            lw    = panel_cfg.rotation[0] ? h_eff : w_eff;
            lh    = panel_cfg.rotation[0] ? w_eff : h_eff;

            for (int n = 0; n < OPS_PER_PHASE; n++)
            begin
                // clears are rare since each one walks the used part of the buffer
                op = ($urandom_range(99) < 3) ? CMD_CLEAR : CMD_PIXEL;
                // mostly on-panel pixels so bytes get read-modify-written repeatedly,
                // the rest anywhere in the coordinate space
                if (lw != 0 && lh != 0 && $urandom_range(99) < 85)
                begin
                    px = COORD_W'($urandom_range(lw - 1));
                    py = COORD_W'($urandom_range(lh - 1));
                end
                else
                begin
                    px = COORD_W'($urandom_range(1023));
                    py = COORD_W'($urandom_range(1023));
                end
                // black often enough that 1 bpp bits get cleared as well as set
                ink = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
                send_frame_op(op, px, py, ink, NOCHK, '0);
            end
        end

        // drain, then settle
        wait_for_idle();
        $display("covered %0d transactions: directed table then %0d random panel settings",
                 ops_taken, N_PHASES);
        $display("results seen: %0d pixels written, %0d rejected, %0d clears, %0d mismatches",
                 n_written, n_rejected, n_cleared, fail_count);
        if (fail_count == 0)
            $display("rotated_framebuffer_pixel_writer_top_test OK");
        else
            $display("rotated_framebuffer_pixel_writer_top_test NOT OK");
        $finish;
    end

endmodule

/* rotated_framebuffer_pixel_writer_top.f */
+incdir+rtl
rtl/rfpw_pkg.sv
rtl/rfpw_cfg.sv
rtl/rfpw_ctrl.sv
rtl/rfpw_dp.sv
rtl/rotated_framebuffer_pixel_writer_top.sv
rtl/rfpw_checker.sv
tb/sv/rotated_framebuffer_pixel_writer_top_test.sv
